// ===== rtl/rnge_pkg.sv =====
// Shared types and constants for the relative neighborhood graph edge finder.
package rnge_pkg;

    localparam int MAX_POINTS_DEFAULT = 64;
    localparam int MIN_SIZE_W         = 7;
    localparam int MATRIX_SIZE_RESET  = 64;
    localparam int DIST_W             = 32;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_SCAN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_Q_START,
        ST_Q_LOAD,
        ST_Z_RUN,
        ST_Z_DRAIN,
        ST_Q_DONE,
        ST_FINISH
    } rnge_state_t;

    typedef struct packed {
        logic write;
        logic start;
        logic rd_pq;
        logic latch_dpq;
        logic z_issue;
        logic q_inc;
        logic push_edge;
        logic push_final;
    } rnge_cmd_t;

    typedef struct packed {
        logic scan_ok;
        logic z_last;
        logic q_last;
        logic kill;
        logic has_pending;
        logic out_free;
    } rnge_sts_t;

endpackage

// ===== rtl/rnge_ctrl.sv =====
// Controller state machine sequencing loads and row scans.
module rnge_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  rnge_pkg::rnge_sts_t sts,
    output rnge_pkg::rnge_cmd_t cmd
);

    rnge_pkg::rnge_state_t state_reg;
    rnge_pkg::rnge_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rnge_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            rnge_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == rnge_pkg::FUNC_LOAD) begin
                        cmd.write = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = rnge_pkg::ST_CHECK;
                    end
                end
            end
            rnge_pkg::ST_CHECK: begin
                state_next = sts.scan_ok ? rnge_pkg::ST_Q_START : rnge_pkg::ST_FINISH;
            end
            rnge_pkg::ST_Q_START: begin
                cmd.rd_pq  = 1'b1;
                state_next = rnge_pkg::ST_Q_LOAD;
            end
            rnge_pkg::ST_Q_LOAD: begin
                cmd.latch_dpq = 1'b1;
                state_next    = rnge_pkg::ST_Z_RUN;
            end
            rnge_pkg::ST_Z_RUN: begin
                cmd.z_issue = 1'b1;
                if (sts.z_last) begin
                    state_next = rnge_pkg::ST_Z_DRAIN;
                end
            end
            rnge_pkg::ST_Z_DRAIN: begin
                state_next = rnge_pkg::ST_Q_DONE;
            end
            rnge_pkg::ST_Q_DONE: begin
                if (sts.kill || !sts.has_pending || sts.out_free) begin
                    cmd.push_edge = !sts.kill;
                    if (sts.q_last) begin
                        state_next = rnge_pkg::ST_FINISH;
                    end else begin
                        cmd.q_inc  = 1'b1;
                        state_next = rnge_pkg::ST_Q_START;
                    end
                end
            end
            rnge_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.push_final = 1'b1;
                    state_next     = rnge_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rnge_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rnge_datapath.sv =====
// Datapath: distance memory, scan counters, triangle test, pending edge and output register.
module rnge_datapath #(
    parameter int MAX_POINTS = rnge_pkg::MAX_POINTS_DEFAULT,
    parameter int IDX_W      = $clog2(MAX_POINTS),
    parameter int SIZE_W     = rnge_pkg::MIN_SIZE_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rnge_pkg::rnge_cmd_t         cmd,
    output rnge_pkg::rnge_sts_t         sts,
    input  logic                        cfg_wr_en,
    input  logic [SIZE_W-1:0]           cfg_wr_data,
    input  logic [IDX_W-1:0]            s_row_index,
    input  logic [IDX_W-1:0]            s_col_index,
    input  logic [rnge_pkg::DIST_W-1:0] s_distance_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [IDX_W-1:0]            m_point_a,
    output logic [IDX_W-1:0]            m_point_b,
    output logic [rnge_pkg::DIST_W-1:0] m_edge_distance,
    output logic                        m_edge_valid,
    output logic                        m_last_result
);

    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic [rnge_pkg::DIST_W-1:0] distance_mem [MEM_DEPTH];

    logic [SIZE_W-1:0]           size_reg;
    logic [SIZE_W-1:0]           n_reg;
    logic [SIZE_W-1:0]           n_next;
    logic [IDX_W-1:0]            p_reg;
    logic [IDX_W-1:0]            q_reg;
    logic [IDX_W-1:0]            z_reg;
    logic [rnge_pkg::DIST_W-1:0] dpq_reg;
    logic [rnge_pkg::DIST_W-1:0] rd_a_reg;
    logic [rnge_pkg::DIST_W-1:0] rd_b_reg;
    logic                        cmp_valid_reg;
    logic                        cmp_skip_reg;
    logic                        kill_reg;
    logic                        kill_next;
    logic                        has_pending_reg;
    logic [IDX_W-1:0]            pend_q_reg;
    logic [rnge_pkg::DIST_W-1:0] pend_dist_reg;
    logic                        m_valid_reg;
    logic [IDX_W-1:0]            out_a_reg;
    logic [IDX_W-1:0]            out_b_reg;
    logic [rnge_pkg::DIST_W-1:0] out_dist_reg;
    logic                        out_edge_reg;
    logic                        out_last_reg;
    logic [ADDR_W-1:0]           addr_a;
    logic [ADDR_W-1:0]           addr_b;
    logic [ADDR_W-1:0]           addr_w;
    logic                        wr_in_range;
    logic                        hit;
    logic                        out_free;
    logic                        push_out;

    assign addr_a      = cmd.rd_pq ? {p_reg, q_reg} : {p_reg, z_reg};
    assign addr_b      = {z_reg, q_reg};
    assign addr_w      = {s_row_index, s_col_index};
    assign wr_in_range = ((IDX_W + 1)'(s_row_index) < (IDX_W + 1)'(MAX_POINTS))
                      && ((IDX_W + 1)'(s_col_index) < (IDX_W + 1)'(MAX_POINTS));

    always_ff @(posedge aclk) begin
        if (cmd.write && wr_in_range) begin
            distance_mem[addr_w] <= s_distance_in;
        end
        rd_a_reg <= distance_mem[addr_a];
        rd_b_reg <= distance_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_W'(rnge_pkg::MATRIX_SIZE_RESET);
        end else if (cfg_wr_en) begin
            size_reg <= cfg_wr_data;
        end
    end

    assign n_next = (size_reg > SIZE_W'(MAX_POINTS)) ? SIZE_W'(MAX_POINTS) : size_reg;

    assign hit = cmp_valid_reg && !cmp_skip_reg
              && (dpq_reg > rd_a_reg) && (dpq_reg > rd_b_reg);
    assign kill_next = cmd.latch_dpq ? 1'b0 : (kill_reg | hit);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            p_reg <= s_row_index;
            n_reg <= n_next;
            q_reg <= '0;
        end else if (cmd.q_inc) begin
            q_reg <= q_reg + IDX_W'(1);
        end
        if (cmd.latch_dpq) begin
            dpq_reg <= rd_a_reg;
            z_reg   <= '0;
        end else if (cmd.z_issue) begin
            z_reg <= z_reg + IDX_W'(1);
        end
        cmp_skip_reg <= (z_reg == p_reg) || (z_reg == q_reg);
        kill_reg     <= kill_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.z_issue;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign push_out = cmd.push_final || (cmd.push_edge && has_pending_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_pending_reg <= 1'b0;
        end else if (cmd.start || cmd.push_final) begin
            has_pending_reg <= 1'b0;
        end else if (cmd.push_edge) begin
            has_pending_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_edge) begin
            pend_q_reg    <= q_reg;
            pend_dist_reg <= dpq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_out) begin
            out_a_reg <= p_reg;
            if (has_pending_reg) begin
                out_b_reg    <= pend_q_reg;
                out_dist_reg <= pend_dist_reg;
                out_edge_reg <= 1'b1;
            end else begin
                out_b_reg    <= '0;
                out_dist_reg <= '0;
                out_edge_reg <= 1'b0;
            end
            out_last_reg <= cmd.push_final;
        end
    end

    assign sts.scan_ok     = (SIZE_W'(p_reg) < n_reg) && (p_reg != '0);
    assign sts.z_last      = SIZE_W'(z_reg) == (n_reg - SIZE_W'(1));
    assign sts.q_last      = q_reg == (p_reg - IDX_W'(1));
    assign sts.kill        = kill_reg;
    assign sts.has_pending = has_pending_reg;
    assign sts.out_free    = out_free;

    assign m_valid         = m_valid_reg;
    assign m_point_a       = out_a_reg;
    assign m_point_b       = out_b_reg;
    assign m_edge_distance = out_dist_reg;
    assign m_edge_valid    = out_edge_reg;
    assign m_last_result   = out_last_reg;

`ifndef SYNTHESIS
    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_out |-> out_free)
        else $error("item pushed into occupied output register");

    a_z_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.z_issue |-> (SIZE_W'(z_reg) < n_reg))
        else $error("z index beyond size in use");

    a_q_below_p: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_pq |-> (q_reg < p_reg))
        else $error("q read at or above p");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_final |=> !has_pending_reg)
        else $error("pending edge left after final item");
`endif

endmodule

// ===== rtl/relative_neighborhood_graph_edges_unit.sv =====
// Relative neighborhood graph edge finder: top level joining controller and datapath.
//
// A load item (func 0) writes one entry of the distance matrix and gives no result;
// entries must be written before any scan reads them. A scan item (func 1) for point p
// tests every q below p against all points z below the size in use, reading d[p][z] and
// d[z][q] from the two read ports of the distance memory at one z per cycle. A scan
// stalls while the result side is not ready; a scan of a point not in use tests no pair.
// Edges come out in rising q with the last one flagged; a row without an edge gives one
// item with m_edge_valid low. The user must write the matrix size register only while
// the block is idle; the block itself does not enforce this.
module relative_neighborhood_graph_edges_unit #(
    parameter int MAX_POINTS = rnge_pkg::MAX_POINTS_DEFAULT,
    parameter int IDX_W      = $clog2(MAX_POINTS),
    parameter int SIZE_W     = ($clog2(MAX_POINTS + 1) > rnge_pkg::MIN_SIZE_W)
                               ? $clog2(MAX_POINTS + 1) : rnge_pkg::MIN_SIZE_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [SIZE_W-1:0]           cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [IDX_W-1:0]            s_row_index,
    input  logic [IDX_W-1:0]            s_col_index,
    input  logic [rnge_pkg::DIST_W-1:0] s_distance_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [IDX_W-1:0]            m_point_a,
    output logic [IDX_W-1:0]            m_point_b,
    output logic [rnge_pkg::DIST_W-1:0] m_edge_distance,
    output logic                        m_edge_valid,
    output logic                        m_last_result
);

    rnge_pkg::rnge_cmd_t cmd;
    rnge_pkg::rnge_sts_t sts;

    rnge_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .sts     (sts),
        .cmd     (cmd)
    );

    rnge_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W),
        .SIZE_W     (SIZE_W)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_distance_in   (s_distance_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_point_a       (m_point_a),
        .m_point_b       (m_point_b),
        .m_edge_distance (m_edge_distance),
        .m_edge_valid    (m_edge_valid),
        .m_last_result   (m_last_result)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the edge finder: random handshakes against an edge predictor.
module tb_top;

    localparam int NPTS          = rnge_pkg::MAX_POINTS_DEFAULT;
    localparam int IDX_W         = $clog2(NPTS);
    localparam int SIZE_W        = rnge_pkg::MIN_SIZE_W;
    localparam int DIST_W        = rnge_pkg::DIST_W;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 50;
    localparam int GAP_PERCENT   = 18;

    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DIST_W-1:0] distance;
    } matrix_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  point_a;
        logic [IDX_W-1:0]  point_b;
        logic [DIST_W-1:0] edge_distance;
        logic              edge_valid;
        logic              last_result;
    } edge_rec_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = SIZE_W'(rnge_pkg::MATRIX_SIZE_RESET);
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_func = rnge_pkg::FUNC_LOAD;
    logic [IDX_W-1:0] s_row_index = '0;
    logic [IDX_W-1:0] s_col_index = '0;
    logic [DIST_W-1:0] s_distance_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [IDX_W-1:0] m_point_a;
    logic [IDX_W-1:0] m_point_b;
    logic [DIST_W-1:0] m_edge_distance;
    logic m_edge_valid;
    logic m_last_result;

    logic [DIST_W-1:0] dist_mirror [NPTS][NPTS];
    logic [SIZE_W-1:0] matrix_size_q = SIZE_W'(rnge_pkg::MATRIX_SIZE_RESET);
    matrix_req_t pending_items[$];
    matrix_req_t cur_item;
    edge_rec_t expected_edges[$];
    bit steady = 1'b0;
    int fail_count = 0;
    int loads_sent = 0;
    int scans_sent = 0;
    int results_checked = 0;
    int edges_checked = 0;
    int cycle_count = 0;

    relative_neighborhood_graph_edges_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_distance_in   (s_distance_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_point_a       (m_point_a),
        .m_point_b       (m_point_b),
        .m_edge_distance (m_edge_distance),
        .m_edge_valid    (m_edge_valid),
        .m_last_result   (m_last_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void predict_row_edges(logic [IDX_W-1:0] p);
        int n;
        int q;
        int z;
        bit kept;
        bit have_prev;
        logic [DIST_W-1:0] dpq;
        edge_rec_t prev;
        n = (int'(matrix_size_q) > NPTS) ? NPTS : int'(matrix_size_q);
        have_prev = 1'b0;
        prev = '0;
        if (int'(p) < n) begin
            for (q = 0; q < int'(p); q++) begin
                dpq = dist_mirror[p][q];
                kept = 1'b1;
                for (z = 0; z < n; z++) begin
                    if (z != int'(p) && z != q && dpq > dist_mirror[p][z]
                        && dpq > dist_mirror[z][q])
                        kept = 1'b0;
                end
                if (kept) begin
                    if (have_prev)
                        expected_edges.push_back(prev);
                    prev = '{point_a: p, point_b: IDX_W'(q), edge_distance: dpq,
                             edge_valid: 1'b1, last_result: 1'b0};
                    have_prev = 1'b1;
                end
            end
        end
        if (have_prev) begin
            prev.last_result = 1'b1;
            expected_edges.push_back(prev);
        end else begin
            expected_edges.push_back('{point_a: p, point_b: '0, edge_distance: '0,
                                       edge_valid: 1'b0, last_result: 1'b1});
        end
    endfunction

    function automatic void record_item(matrix_req_t it);
        if (it.func == rnge_pkg::FUNC_LOAD) begin
            dist_mirror[it.row][it.col] = it.distance;
            loads_sent++;
        end else begin
            predict_row_edges(it.row);
            scans_sent++;
        end
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            4: return 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: return DIST_W'($urandom_range(0, 15)) << 16;
        endcase
    endfunction

    task automatic queue_load(int r, int c, logic [DIST_W-1:0] d);
        pending_items.push_back('{func: rnge_pkg::FUNC_LOAD, row: IDX_W'(r), col: IDX_W'(c),
                                  distance: d});
    endtask

    task automatic queue_scan(int p);
        pending_items.push_back('{func: rnge_pkg::FUNC_SCAN, row: IDX_W'(p),
                                  col: IDX_W'($urandom), distance: $urandom});
    endtask

    task automatic refresh_block(int n);
        int r;
        int c;
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                queue_load(r, c, pick_distance());
    endtask

    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_edges.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_size(int v);
        wait_quiet();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= SIZE_W'(v);
        matrix_size_q = SIZE_W'(v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int n, int count);
        int k;
        int roll;
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
                queue_scan($urandom_range(1, n - 1));
            else if (roll < 75)
                queue_scan($urandom_range(0, NPTS - 1));
            else if (roll < 90)
                queue_load($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_distance());
            else
                queue_load($urandom_range(0, NPTS - 1), $urandom_range(0, NPTS - 1),
                           pick_distance());
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                record_item(cur_item);
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0
                    && (steady || $urandom_range(0, 99) >= GAP_PERCENT)) begin
                    cur_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_func <= cur_item.func;
                    s_row_index <= cur_item.row;
                    s_col_index <= cur_item.col;
                    s_distance_in <= cur_item.distance;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= GAP_PERCENT);
        end
    end

    always @(posedge aclk) begin
        edge_rec_t got;
        edge_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{point_a: m_point_a, point_b: m_point_b, edge_distance: m_edge_distance,
                    edge_valid: m_edge_valid, last_result: m_last_result};
            results_checked++;
            if (m_edge_valid === 1'b1)
                edges_checked++;
            if (expected_edges.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected item a=%0d b=%0d dist=%h valid=%b last=%b",
                             $time, got.point_a, got.point_b, got.edge_distance,
                             got.edge_valid, got.last_result);
            end else begin
                want = expected_edges.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"%0t: mismatch expected a=%0d b=%0d dist=%h valid=%b last=%b,",
                                  " actual a=%0d b=%0d dist=%h valid=%b last=%b"},
                                 $time, want.point_a, want.point_b, want.edge_distance,
                                 want.edge_valid, want.last_result, got.point_a, got.point_b,
                                 got.edge_distance, got.edge_valid, got.last_result);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items pending and %0d results outstanding",
                     $time, pending_items.size(), expected_edges.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // point zero reads nothing, safe before any load
        queue_scan(0);
        wait_quiet();

        write_size(3);
        refresh_block(3);
        queue_load(2, 0, 32'h0005_0000);
        queue_load(2, 1, 32'h0003_0000);
        queue_load(1, 0, 32'h0003_0000);
        queue_load(0, 1, 32'h0009_0000);
        queue_scan(2);
        queue_load(2, 0, 32'h0003_0000);
        queue_scan(2);
        queue_load(2, 0, 32'hFFFF_FFFF);
        queue_load(2, 1, 32'hFFFF_FFFE);
        queue_load(1, 0, 32'h0000_0000);
        queue_scan(2);
        queue_load(2, 0, 32'h0000_0000);
        queue_scan(2);
        queue_scan(1);
        queue_scan(3);
        queue_scan(NPTS - 1);

        write_size(0);
        queue_scan(0);
        queue_scan(NPTS - 1);
        write_size(1);
        queue_scan(1);
        write_size(2);
        queue_scan(1);
        write_size(127);
        queue_scan(0);

        write_size(4);
        wait_quiet();
        steady = 1'b1;
        refresh_block(4);
        random_phase(4, 20);
        wait_quiet();
        steady = 1'b0;

        write_size($urandom_range(5, 6));
        refresh_block(int'(matrix_size_q));
        random_phase(int'(matrix_size_q), 24);
        write_size(3);
        refresh_block(int'(matrix_size_q));
        random_phase(int'(matrix_size_q), 8);
        wait_quiet();

        $display("Covered %0d loads and %0d scans at sizes 0 to 6 and one size above the store.",
                 loads_sent, scans_sent);
        $display("Checked %0d results, %0d of them edges, with random gaps on both sides.",
                 results_checked, edges_checked);
        if (fail_count == 0 && expected_edges.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rnge_pkg.sv
rtl/rnge_ctrl.sv
rtl/rnge_datapath.sv
rtl/relative_neighborhood_graph_edges_unit.sv
tb/tb_top.sv
